// File: rtl/core/mpe_pkg.sv
`timescale 1ns / 1ps
// mpe_pkg: shared types, codes, divider interface and the monomial exponent table.
package mpe_pkg;

  localparam int DIM       = 4;
  localparam int MAX_ORDER = 3;
  localparam int NUM_COEFS = 35;

  localparam int EXP_W    = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
  localparam int AXIS_W   = 2;
  localparam int NUM_W    = 50;  // (x - low) << 16 and (m * e) << 16, signed
  localparam int DEN_W    = 33;  // high - low, signed
  localparam int PADDR_W  = 5;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_VALUE = 2'd1,
    FUNC_GRAD  = 2'd2,
    FUNC_DERIV = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [5:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] point_0;
    logic signed [31:0] point_1;
    logic signed [31:0] point_2;
    logic signed [31:0] point_3;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic [AXIS_W-1:0]  axis;
    logic               last;
    status_e            status;
  } out_item_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
    logic               sat;
  } div_rsp_t;

  typedef logic [EXP_W-1:0] expo_t;
  typedef expo_t [DIM-1:0]  expv_t;

  // Exponent vectors are walked in ascending lexicographic order, parameter 0 most significant.
  function automatic int count_mono();
    int                     n;
    int                     sum;
    logic                   ok;
    logic [EXP_W*DIM-1:0]   v;
    n = 0;
    for (int c = 0; c < (1 << (EXP_W * DIM)); c++) begin
      v   = (EXP_W * DIM)'(c);
      sum = 0;
      ok  = 1'b1;
      for (int i = 0; i < DIM; i++) begin
        sum += int'(v[(DIM-1-i)*EXP_W +: EXP_W]);
        if (int'(v[(DIM-1-i)*EXP_W +: EXP_W]) > MAX_ORDER) ok = 1'b0;
      end
      if (ok && sum <= MAX_ORDER) n++;
    end
    return n;
  endfunction

  localparam int NUM_MONO   = count_mono();
  localparam int MONO_IDX_W = (NUM_MONO > 1) ? $clog2(NUM_MONO) : 1;

  typedef expv_t [NUM_MONO-1:0] expo_tbl_t;

  function automatic expo_tbl_t build_expo();
    expo_tbl_t            t;
    int                   n;
    int                   sum;
    logic                 ok;
    logic [EXP_W*DIM-1:0] v;
    t = '0;
    n = 0;
    for (int c = 0; c < (1 << (EXP_W * DIM)); c++) begin
      v   = (EXP_W * DIM)'(c);
      sum = 0;
      ok  = 1'b1;
      for (int i = 0; i < DIM; i++) begin
        sum += int'(v[(DIM-1-i)*EXP_W +: EXP_W]);
        if (int'(v[(DIM-1-i)*EXP_W +: EXP_W]) > MAX_ORDER) ok = 1'b0;
      end
      if (ok && sum <= MAX_ORDER) begin
        for (int i = 0; i < DIM; i++) begin
          t[n][i] = v[(DIM-1-i)*EXP_W +: EXP_W];
        end
        n++;
      end
    end
    return t;
  endfunction

  localparam expo_tbl_t EXPO_TBL = build_expo();

endpackage

// File: rtl/core/mpe_ram.sv
`timescale 1ns / 1ps
// mpe_ram: generic single-port-write, single-port-read RAM with registered read data.
module mpe_ram #(
  parameter int Width = 32,
  parameter int Depth = 35
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mpe_div.sv
`timescale 1ns / 1ps
// mpe_div: signed restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
module mpe_div import mpe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_e;

  dstate_e          state_q;
  logic [4:0]       cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] ad_q;
  logic [31:0]      dvd_q;
  logic [31:0]      quo_q;
  logic             neg_q;
  logic             big_q;
  div_rsp_t         rsp_q;

  logic [NUM_W-1:0] an;
  logic [DEN_W-1:0] ad;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    an    = req_i.num[NUM_W-1] ? (~req_i.num + 1'b1) : req_i.num;
    ad    = req_i.den[DEN_W-1] ? (~req_i.den + 1'b1) : req_i.den;
    trial = {rem_q, dvd_q[31]};
    fits  = trial >= {1'b0, ad_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      ad_q    <= '0;
      dvd_q   <= '0;
      quo_q   <= '0;
      neg_q   <= 1'b0;
      big_q   <= 1'b0;
      rsp_q   <= '0;
    end else begin
      rsp_q.done <= (state_q == D_FIN);
      case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            ad_q  <= ad;
            neg_q <= req_i.num[NUM_W-1] ^ req_i.den[DEN_W-1];
            // quotient of 2^32 or more saturates whatever the sign
            big_q <= DEN_W'(an[NUM_W-1:32]) >= ad;
            rem_q <= DEN_W'(an[NUM_W-1:32]);
            dvd_q <= an[31:0];
            quo_q <= '0;
            cnt_q <= '1;
            state_q <= (DEN_W'(an[NUM_W-1:32]) >= ad) ? D_FIN : D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= fits ? DEN_W'(trial - {1'b0, ad_q}) : DEN_W'(trial);
          dvd_q <= {dvd_q[30:0], 1'b0};
          quo_q <= {quo_q[30:0], fits};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= D_FIN;
        end
        D_FIN: begin
          if (big_q) begin
            rsp_q.sat <= 1'b1;
            rsp_q.quo <= neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else if (!neg_q) begin
            rsp_q.sat <= quo_q[31];
            rsp_q.quo <= quo_q[31] ? 32'sh7FFF_FFFF : $signed(quo_q);
          end else begin
            rsp_q.sat <= quo_q[31] && (|quo_q[30:0]);
            rsp_q.quo <= (quo_q[31] && (|quo_q[30:0])) ? 32'sh8000_0000 : $signed(-quo_q);
          end
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o = rsp_q;

endmodule

// File: rtl/core/multivariate_polynomial_evaluator_unit.sv
`timescale 1ns / 1ps
// Multivariate polynomial evaluator: value, gradient and derivative of a stored polynomial.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): one beat either writes a coefficient
// (func write, no result) or gives a point to evaluate. Output channel
// (out_valid_o/out_ready_i, out_data_o): one result beat for value and derivative, four beats
// for a gradient, the last flagged. Range registers sit on the APB port; the user must write
// them only while idle, as the block does not enforce it. One item is worked at a time;
// in_ready_o is high only when the sequencer is idle. Each coordinate is scaled through the
// shared 32-step divider. A value then walks all 35 terms. Gradient and derivative make four
// passes; every term with a nonzero exponent in that axis adds a divider run.
// A zero-width range skips all arithmetic and returns zeros.
// Results go out through an output register, so the next item is taken while the last result
// still waits; a stalled receiver holds the sequencer only when a further result is ready.
// Reset clears the sequencer and sets ranges to [0.0, 1.0]; coefficients are undefined
// until written.
module multivariate_polynomial_evaluator_unit import mpe_pkg::*; #(
  parameter int NumCoefs = NUM_COEFS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NumTerms = (NumCoefs < NUM_MONO) ? NumCoefs : NUM_MONO;
  localparam int AddrW    = (NumCoefs > 1) ? $clog2(NumCoefs) : 1;
  localparam int TermW    = $clog2(NumTerms + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ZERO, S_SCALE, S_SCALE_WAIT, S_TERM, S_POW, S_POW_WB,
    S_GDIV, S_GDIV_WAIT, S_CMUL, S_ACC, S_PASS_END, S_EMIT
  } state_e;

  state_e                    state_q, ret_q;
  func_e                     func_q;
  logic signed [31:0]        low_q  [DIM];
  logic signed [31:0]        high_q [DIM];
  logic signed [31:0]        pt_q   [DIM];
  logic signed [DEN_W-1:0]   den_q  [DIM];
  logic signed [31:0]        s_q    [DIM];
  logic                      ssat_q;
  logic [AXIS_W-1:0]         ax_q;
  logic [AXIS_W-1:0]         vi_q;
  expo_t                     vn_q;
  logic [TermW-1:0]          k_q;
  logic signed [31:0]        m_q;
  logic signed [63:0]        prod_q;
  logic signed [63:0]        acc_q;
  logic                      sat_q;
  logic signed [63:0]        dsum_q;
  logic                      dsat_q;
  out_item_t                 pend_q;
  out_item_t                 out_q;
  logic                      out_valid_q;

  // configuration port
  logic                      cfg_wr;
  logic [AXIS_W-1:0]         reg_axis;
  logic                      reg_hi;

  assign cfg_wr   = psel && penable && pwrite;
  assign reg_axis = paddr[PADDR_W-1:3];
  assign reg_hi   = paddr[2];
  assign pready   = 1'b1;
  assign prdata   = reg_hi ? high_q[reg_axis] : low_q[reg_axis];

  function automatic logic [32:0] sat32(input logic signed [47:0] v);
    if (v[47:31] != {17{v[31]}}) return {1'b1, v[47] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [64:0] sadd64(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return {1'b1, s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
    return {1'b0, s[63:0]};
  endfunction

  function automatic expo_t pow_cnt(input expv_t ev, input logic [AXIS_W-1:0] vi,
                                    input logic [AXIS_W-1:0] ax, input logic grad);
    if (grad && vi == ax) return ev[vi] - 1'b1;
    return ev[vi];
  endfunction

  // datapath
  logic                      accept;
  logic                      grad_mode;
  logic                      ax_last;
  logic                      term_end;
  logic                      term_skip;
  expv_t                     ev;
  logic signed [DEN_W-1:0]   den_w [DIM];
  logic                      zero_w;
  logic signed [DEN_W-1:0]   diff;
  logic signed [33:0]        m_ext;
  logic signed [33:0]        m_xe;
  logic signed [31:0]        mul_a;
  logic [32:0]               pw;
  logic [64:0]               acc_sum;
  logic [64:0]               der_sum;
  logic                      der_sat;
  logic                      zero_last;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic                      ram_we;
  logic                      ram_re;
  logic [31:0]               ram_rdata;

  assign in_ready_o  = state_q == S_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign grad_mode   = func_q != FUNC_VALUE;
  assign ax_last     = ax_q == AXIS_W'(DIM - 1);
  assign term_end    = k_q == TermW'(NumTerms);
  assign ev          = EXPO_TBL[MONO_IDX_W'(k_q)];
  assign term_skip   = grad_mode && (ev[ax_q] == '0);
  assign zero_last   = (func_q != FUNC_GRAD) || ax_last;

  always_comb begin
    zero_w = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      den_w[i] = {high_q[i][31], high_q[i]} - {low_q[i][31], low_q[i]};
      if (den_w[i] == '0) zero_w = 1'b1;
    end
  end

  always_comb begin
    diff  = {pt_q[ax_q][31], pt_q[ax_q]} - {low_q[ax_q][31], low_q[ax_q]};
    m_ext = {{2{m_q[31]}}, m_q};
    m_xe  = m_ext * $signed({1'b0, ev[ax_q]});
    div_req.start = (state_q == S_SCALE) || (state_q == S_GDIV);
    div_req.num   = (state_q == S_SCALE) ? {diff[DEN_W-1], diff, 16'h0000} : {m_xe, 16'h0000};
    div_req.den   = den_q[ax_q];
    mul_a   = (state_q == S_CMUL) ? $signed(ram_rdata) : s_q[vi_q];
    pw      = sat32(prod_q[63:16]);
    acc_sum = sadd64(acc_q, prod_q);
    der_sum = sadd64(dsum_q, acc_q);
    der_sat = dsat_q || sat_q || der_sum[64];
  end

  assign ram_we = accept && (in_data_i.func == FUNC_WRITE) &&
                  (32'(in_data_i.coef_index) < NumCoefs);
  // reads happen only while busy and writes only while idle, so they never meet
  assign ram_re = (state_q == S_TERM) && !term_end && !term_skip;

  mpe_ram #(
    .Width (32),
    .Depth (NumCoefs)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(in_data_i.coef_index)),
    .wdata_i (in_data_i.coef_value),
    .re_i    (ram_re),
    .raddr_i (AddrW'(k_q)),
    .rdata_o (ram_rdata)
  );

  mpe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      func_q      <= FUNC_VALUE;
      for (int i = 0; i < DIM; i++) begin
        low_q[i]  <= '0;
        high_q[i] <= Q_ONE;
        pt_q[i]   <= '0;
        den_q[i]  <= '0;
        s_q[i]    <= '0;
      end
      ssat_q      <= 1'b0;
      ax_q        <= '0;
      vi_q        <= '0;
      vn_q        <= '0;
      k_q         <= '0;
      m_q         <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      dsum_q      <= '0;
      dsat_q      <= 1'b0;
      pend_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // S_EMIT sets the output register itself
      if (out_ready_i && state_q != S_EMIT) out_valid_q <= 1'b0;

      if (cfg_wr) begin
        if (reg_hi) high_q[reg_axis] <= pwdata;
        else low_q[reg_axis] <= pwdata;
      end

      case (state_q)
        S_IDLE: begin
          if (accept && in_data_i.func != FUNC_WRITE) begin
            func_q   <= in_data_i.func;
            pt_q[0]  <= in_data_i.point_0;
            pt_q[1]  <= in_data_i.point_1;
            pt_q[2]  <= in_data_i.point_2;
            pt_q[3]  <= in_data_i.point_3;
            for (int i = 0; i < DIM; i++) den_q[i] <= den_w[i];
            ax_q     <= '0;
            ssat_q   <= 1'b0;
            state_q  <= zero_w ? S_ZERO : S_SCALE;
          end
        end
        S_ZERO: begin
          pend_q.result <= '0;
          pend_q.axis   <= (func_q == FUNC_GRAD) ? ax_q : '0;
          pend_q.last   <= zero_last;
          pend_q.status <= ST_ZERO;
          ax_q          <= ax_q + 1'b1;
          ret_q         <= zero_last ? S_IDLE : S_ZERO;
          state_q       <= S_EMIT;
        end
        S_SCALE: state_q <= S_SCALE_WAIT;
        S_SCALE_WAIT: begin
          if (div_rsp.done) begin
            s_q[ax_q] <= div_rsp.quo;
            ssat_q    <= ssat_q || div_rsp.sat;
            if (ax_last) begin
              ax_q    <= '0;
              k_q     <= '0;
              acc_q   <= '0;
              sat_q   <= ssat_q || div_rsp.sat;
              dsum_q  <= '0;
              dsat_q  <= 1'b0;
              state_q <= S_TERM;
            end else begin
              ax_q    <= ax_q + 1'b1;
              state_q <= S_SCALE;
            end
          end
        end
        S_TERM: begin
          if (term_end) begin
            state_q <= S_PASS_END;
          end else if (term_skip) begin
            k_q <= k_q + 1'b1;
          end else begin
            m_q     <= Q_ONE;
            vi_q    <= '0;
            vn_q    <= pow_cnt(ev, '0, ax_q, grad_mode);
            state_q <= S_POW;
          end
        end
        S_POW: begin
          if (vn_q != '0) begin
            prod_q  <= mul_a * m_q;
            state_q <= S_POW_WB;
          end else if (vi_q == AXIS_W'(DIM - 1)) begin
            state_q <= grad_mode ? S_GDIV : S_CMUL;
          end else begin
            vi_q <= vi_q + 1'b1;
            vn_q <= pow_cnt(ev, vi_q + 1'b1, ax_q, grad_mode);
          end
        end
        S_POW_WB: begin
          m_q     <= $signed(pw[31:0]);
          sat_q   <= sat_q || pw[32];
          vn_q    <= vn_q - 1'b1;
          state_q <= S_POW;
        end
        S_GDIV: state_q <= S_GDIV_WAIT;
        S_GDIV_WAIT: begin
          if (div_rsp.done) begin
            m_q     <= div_rsp.quo;
            sat_q   <= sat_q || div_rsp.sat;
            state_q <= S_CMUL;
          end
        end
        S_CMUL: begin
          prod_q  <= mul_a * m_q;
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q   <= $signed(acc_sum[63:0]);
          sat_q   <= sat_q || acc_sum[64];
          k_q     <= k_q + 1'b1;
          state_q <= S_TERM;
        end
        S_PASS_END: begin
          case (func_q)
            FUNC_GRAD: begin
              pend_q.result <= acc_q;
              pend_q.axis   <= ax_q;
              pend_q.last   <= ax_last;
              pend_q.status <= sat_q ? ST_SAT : ST_OK;
              ret_q         <= ax_last ? S_IDLE : S_TERM;
              state_q       <= S_EMIT;
              ax_q          <= ax_q + 1'b1;
              k_q           <= '0;
              acc_q         <= '0;
              sat_q         <= ssat_q;
            end
            FUNC_DERIV: begin
              dsum_q <= $signed(der_sum[63:0]);
              dsat_q <= der_sat;
              if (ax_last) begin
                pend_q.result <= $signed(der_sum[63:0]);
                pend_q.axis   <= '0;
                pend_q.last   <= 1'b1;
                pend_q.status <= der_sat ? ST_SAT : ST_OK;
                ret_q         <= S_IDLE;
                state_q       <= S_EMIT;
              end else begin
                ax_q    <= ax_q + 1'b1;
                k_q     <= '0;
                acc_q   <= '0;
                sat_q   <= ssat_q;
                state_q <= S_TERM;
              end
            end
            default: begin
              pend_q.result <= acc_q;
              pend_q.axis   <= '0;
              pend_q.last   <= 1'b1;
              pend_q.status <= sat_q ? ST_SAT : ST_OK;
              ret_q         <= S_IDLE;
              state_q       <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= pend_q;
            out_valid_q <= 1'b1;
            state_q     <= ret_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/mpe_chk.sv
`timescale 1ns / 1ps
// mpe_chk: port-level assertions for the polynomial evaluator, bound to the top level.
module mpe_chk import mpe_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // a coefficient write leaves the block idle
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func == FUNC_WRITE |=> in_ready_o)
    else $error("coefficient write made the block busy");

  // an evaluation beat occupies the sequencer
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func != FUNC_WRITE |=> !in_ready_o)
    else $error("evaluation beat did not start the sequencer");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_ZERO |-> out_data_o.result == '0)
    else $error("zero-width status with nonzero result");

  // only gradient beats carry an axis; last goes with the final axis
  a_grad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.axis != '0 |->
      out_data_o.last == (out_data_o.axis == AXIS_W'(DIM - 1)))
    else $error("gradient last flag does not match axis");

endmodule

bind multivariate_polynomial_evaluator_unit mpe_chk u_mpe_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: test/tb_multivariate_polynomial_evaluator_unit.sv
`timescale 1ns / 1ps
// Testbench for the multivariate polynomial evaluator: predicted results checked beat by beat.
module tb_multivariate_polynomial_evaluator_unit;
  import mpe_pkg::*;

  localparam longint CYCLE_LIMIT = 6000000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam longint S64_MIN = 64'h8000_0000_0000_0000;
  localparam int NUM_REGS = 2 * DIM;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  multivariate_polynomial_evaluator_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow of the block's state
  longint    range_lo[DIM];
  longint    range_hi[DIM];
  longint    coef_mem[NUM_COEFS];
  int        mono_exp[NUM_COEFS][DIM];
  out_item_t pending_results[$];

  int     errors;
  longint cycles = 0;
  bit     calm;      // no idling on either side while set
  bit     hold_go;
  bit     hold_done;
  int     hold_cnt;
  int     rx_wait;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  function automatic longint sat32(longint v, inout bit flag);
    if (v > S32_MAX) begin
      flag = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      flag = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b, inout bit flag);
    longint p;
    p = a * b;
    return sat32(p >>> 16, flag);
  endfunction

  function automatic longint add64(longint a, longint b, inout bit flag);
    if (b > 0 && a > S64_MAX - b) begin
      flag = 1'b1;
      return S64_MAX;
    end
    if (b < 0 && a < S64_MIN - b) begin
      flag = 1'b1;
      return S64_MIN;
    end
    return a + b;
  endfunction

  function automatic void push_result(longint r, int axis, bit last, status_e st);
    out_item_t o;
    o.result = r;
    o.axis   = AXIS_W'(axis);
    o.last   = last;
    o.status = st;
    pending_results = {pending_results, o};
  endfunction

  function automatic void build_monomials();
    int d[DIM];
    int sum;
    int i;
    int n;
    for (i = 0; i < DIM; i++) d[i] = 0;
    n = 0;
    forever begin
      sum = 0;
      for (i = 0; i < DIM; i++) sum += d[i];
      if (sum <= MAX_ORDER && n < NUM_COEFS) begin
        for (i = 0; i < DIM; i++) mono_exp[n][i] = d[i];
        n++;
      end
      i = DIM - 1;
      while (i >= 0 && d[i] == MAX_ORDER) begin
        d[i] = 0;
        i--;
      end
      if (i < 0) break;
      d[i]++;
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    longint s[DIM];
    longint den[DIM];
    longint acc[DIM];
    longint x;
    longint m;
    longint v;
    bit     gsat[DIM];
    bit     zero_w;
    bit     scale_sat;
    bit     sat;
    int     nres;
    int     p;
    if (it.func == FUNC_WRITE) begin
      if (it.coef_index < NUM_COEFS) coef_mem[it.coef_index] = longint'(it.coef_value);
      return;
    end
    zero_w    = 1'b0;
    scale_sat = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      case (i)
        0: x = it.point_0;
        1: x = it.point_1;
        2: x = it.point_2;
        default: x = it.point_3;
      endcase
      den[i] = range_hi[i] - range_lo[i];
      if (den[i] == 0) begin
        zero_w = 1'b1;
        s[i] = 0;
      end else begin
        s[i] = sat32(((x - range_lo[i]) * 65536) / den[i], scale_sat);
      end
    end
    nres = (it.func == FUNC_GRAD) ? DIM : 1;
    if (zero_w) begin
      for (int k = 0; k < nres; k++)
        push_result(0, (it.func == FUNC_GRAD) ? k : 0, k == nres - 1, ST_ZERO);
      return;
    end
    if (it.func == FUNC_VALUE) begin
      v   = 0;
      sat = scale_sat;
      for (int k = 0; k < NUM_COEFS; k++) begin
        m = 65536;
        for (int i = 0; i < DIM; i++)
          for (int n = 0; n < mono_exp[k][i]; n++) m = qmul(m, s[i], sat);
        v = add64(v, coef_mem[k] * m, sat);
      end
      push_result(v, 0, 1'b1, sat ? ST_SAT : ST_OK);
      return;
    end
    for (int c = 0; c < DIM; c++) begin
      acc[c]  = 0;
      gsat[c] = scale_sat;
      for (int k = 0; k < NUM_COEFS; k++) begin
        if (mono_exp[k][c] == 0) continue;
        m = 65536;
        for (int i = 0; i < DIM; i++) begin
          p = (i == c) ? mono_exp[k][i] - 1 : mono_exp[k][i];
          for (int n = 0; n < p; n++) m = qmul(m, s[i], gsat[c]);
        end
        m = sat32((m * mono_exp[k][c] * 65536) / den[c], gsat[c]);
        acc[c] = add64(acc[c], coef_mem[k] * m, gsat[c]);
      end
    end
    if (it.func == FUNC_GRAD) begin
      for (int c = 0; c < DIM; c++)
        push_result(acc[c], c, c == DIM - 1, gsat[c] ? ST_SAT : ST_OK);
    end else begin
      v   = 0;
      sat = 1'b0;
      for (int c = 0; c < DIM; c++) begin
        if (gsat[c]) sat = 1'b1;
        v = add64(v, acc[c], sat);
      end
      push_result(v, 0, 1'b1, sat ? ST_SAT : ST_OK);
    end
  endfunction

  // ---------------- result side ----------------

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Receiver: random stall per beat, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    int w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= 0;
      hold_done   <= 1'b0;
      rx_wait     <= 0;
    end else if (hold_go && !hold_done) begin
      out_ready_i <= 1'b0;
      if (hold_cnt < 8000) hold_cnt <= hold_cnt + 1;
      else hold_done <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait     <= rx_wait - 1;
      out_ready_i <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      w = idle_draw();
      out_ready_i <= (w == 0);
      rx_wait     <= (w > 0) ? w - 1 : 0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.result !== want.result || out_data_o.axis !== want.axis ||
            out_data_o.last !== want.last || out_data_o.status !== want.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp result %h axis %0d last %0b status %0d, got %h %0d %0b %0d",
                     want.result, want.axis, want.last, want.status, out_data_o.result,
                     out_data_o.axis, out_data_o.last, out_data_o.status);
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic send_item(in_item_t it);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // writes yield no beat; let the sequencer settle before touching registers
    do @(posedge clk_i); while (!in_ready_o);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(int idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * idx);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (idx[0]) range_hi[idx >> 1] = longint'(signed'(val));
    else range_lo[idx >> 1] = longint'(signed'(val));
  endtask

  task automatic set_range(int axis, logic [31:0] lo, logic [31:0] hi);
    reg_write(2 * axis, lo);
    reg_write(2 * axis + 1, hi);
  endtask

  function automatic logic [31:0] pick_coord(int axis);
    longint span;
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return range_lo[axis][31:0];
      3: return range_hi[axis][31:0];
      default: begin
        span = range_hi[axis] - range_lo[axis];
        return 32'(range_lo[axis] + (span * $urandom_range(0, 65536)) / 65536);
      end
    endcase
  endfunction

  function automatic in_item_t make_eval(func_e f);
    in_item_t it;
    it.func       = f;
    it.coef_index = 6'($urandom);
    it.coef_value = $urandom;
    it.point_0    = pick_coord(0);
    it.point_1    = pick_coord(1);
    it.point_2    = pick_coord(2);
    it.point_3    = pick_coord(3);
    return it;
  endfunction

  function automatic in_item_t make_write(int idx, logic [31:0] val);
    in_item_t it;
    it         = make_eval(FUNC_WRITE);
    it.coef_index = 6'(idx);
    it.coef_value = val;
    return it;
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic in_item_t make_random();
    case ($urandom_range(0, 9))
      0, 1: return make_write($urandom_range(0, NUM_COEFS - 1), pick_coef());
      2: return make_write($urandom_range(NUM_COEFS, 63), $urandom);
      3, 4, 5: return make_eval(FUNC_VALUE);
      6, 7: return make_eval(FUNC_GRAD);
      default: return make_eval(FUNC_DERIV);
    endcase
  endfunction

  // ---------------- tests ----------------

  task automatic test_coef_load();
    // every slot written before any evaluation reads it
    for (int k = 0; k < NUM_COEFS; k++) send_item(make_write(k, pick_coef()));
    send_item(make_write(63, 32'hffff_ffff));
    send_item(make_write(NUM_COEFS, 32'h1234_5678));
  endtask

  task automatic test_directed();
    in_item_t it;
    send_item(make_write(0, 32'h7fff_ffff));
    send_item(make_write(NUM_COEFS - 1, 32'h8000_0000));
    it = make_eval(FUNC_VALUE);
    it.point_0 = 32'h0001_0000; it.point_1 = 0; it.point_2 = 32'h0000_8000; it.point_3 = 0;
    send_item(it);
    it.func = FUNC_GRAD;  send_item(it);
    it.func = FUNC_DERIV; send_item(it);
    it.point_0 = 32'h7fff_ffff; it.point_1 = 32'h8000_0000;
    it.point_2 = 32'h7fff_ffff; it.point_3 = 32'h8000_0000;
    it.func = FUNC_VALUE; send_item(it);
    it.func = FUNC_GRAD;  send_item(it);
    it.func = FUNC_DERIV; send_item(it);
    it.point_0 = 0; it.point_1 = 0; it.point_2 = 0; it.point_3 = 0;
    it.func = FUNC_VALUE; send_item(it);
    send_item(make_write(0, 32'h0000_0000));
    drain();
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send_item(make_random());
    end
    calm = 1'b0;
  endtask

  task automatic test_range_settings();
    // widest span per axis, then reversed, then very narrow for scaling overflow
    for (int a = 0; a < DIM; a++) set_range(a, 32'h8000_0000, 32'h7fff_ffff);
    run_random(30);
    drain();
    for (int a = 0; a < DIM; a++) set_range(a, 32'h7fff_ffff, 32'h8000_0000);
    run_random(20);
    drain();
    for (int a = 0; a < DIM; a++) set_range(a, 0, 1);
    run_random(20);
    drain();
    // zero-width range on one axis
    set_range(0, 0, 32'h0001_0000);
    set_range(1, 32'hfffe_0000, 32'h0002_0000);
    set_range(2, 32'h0003_0000, 32'h0003_0000);
    set_range(3, 0, 32'h0001_0000);
    for (int f = FUNC_VALUE; f <= FUNC_DERIV; f++) send_item(make_eval(func_e'(f)));
    run_random(20);
    drain();
    set_range(2, 32'hffff_0000, 32'h0001_0000);
  endtask

  task automatic test_backpressure();
    hold_go <= 1'b1;
    for (int n = 0; n < 6; n++) send_item(make_eval(FUNC_VALUE));
    for (int n = 0; n < 3; n++) send_item(make_eval(FUNC_GRAD));
    drain();
  endtask

  task automatic test_random_ranges();
    for (int phase = 0; phase < 6; phase++) begin
      for (int a = 0; a < DIM; a++) begin
        if ($urandom_range(0, 1)) set_range(a, $urandom, $urandom);
        else set_range(a, 32'(-int'($urandom_range(0, 8 << 16))),
                          32'($urandom_range(1, 8 << 16)));
      end
      run_random(50);
      drain();
    end
  endtask

  initial begin
    clk_i      = 1'b0;
    errors     = 0;
    calm       = 1'b0;
    hold_go    = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    for (int a = 0; a < DIM; a++) begin
      range_lo[a] = 0;
      range_hi[a] = 65536;
    end
    for (int k = 0; k < NUM_COEFS; k++) coef_mem[k] = 0;
    build_monomials();
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_coef_load();
    test_directed();
    test_backpressure();
    test_range_settings();
    test_random_ranges();
    run_random(60);
    drain();

    if (pending_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
